[rtl/hta_pkg.sv]
// Shared types and constants for the handle table allocator.
// Depends on nothing; hta_free_find and handle_table_allocator import it.
package hta_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int PTR_W       = 64;

  localparam int HANDLE_W    = 8;
  localparam int PTR_FIELD_W = 64;
  localparam int TYPE_W      = 4;

  localparam int IDX_W    = (TABLE_DEPTH > 4) ? $clog2(TABLE_DEPTH) : 2;
  localparam int LO_W     = (IDX_W + 1) / 2;
  localparam int GI_W     = IDX_W - LO_W;
  localparam int GRP_W    = 1 << LO_W;
  localparam int NUM_GRP  = 1 << GI_W;
  localparam int NUM_SLOT = 1 << IDX_W;
  localparam int ENTRY_W  = TYPE_W + PTR_W;

  localparam logic [TYPE_W-1:0] TYPE_EMPTY = '0;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_GETTYPE = 2'd2,
    OP_REMOVE  = 2'd3
  } hta_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } hta_state_t;

  typedef struct packed {
    hta_op_t                  opcode;
    logic [HANDLE_W-1:0]      handle_index;
    logic [PTR_FIELD_W-1:0]   pointer_value;
    logic [TYPE_W-1:0]        entry_type;
  } hta_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]      new_handle;
    logic [PTR_FIELD_W-1:0]   read_pointer;
    logic [TYPE_W-1:0]        read_type;
  } hta_out_t;

  typedef struct packed {
    logic             load;
    logic             set_en;
    logic [IDX_W-1:0] set_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } hta_occ_cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] slot;
  } hta_free_t;

endpackage

[rtl/hta_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing.
module hta_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/hta_free_find.sv]
// Occupancy bitmap and two-step lowest-free-slot search (group, then slot).
// Depends on hta_pkg.
module hta_free_find (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hta_pkg::hta_occ_cmd_t      cmd,
  input  logic [hta_pkg::IDX_W-1:0]  q_idx,
  output logic                       q_occ,
  output hta_pkg::hta_free_t         free
);
  import hta_pkg::*;

  logic [NUM_SLOT-1:0] occ_r, occ_nxt, occ_eff, rsv;
  logic [NUM_GRP-1:0]  grp_full;
  logic [GI_W-1:0]     grp_r;
  logic                grp_ok_r;
  logic [GRP_W-1:0]    grp_bits;

  function automatic logic [GI_W-1:0] first_open(input logic [NUM_GRP-1:0] v);
    logic [GI_W-1:0] r;
    r = '0;
    for (int i = NUM_GRP - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = GI_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [LO_W-1:0] low_free(input logic [GRP_W-1:0] v);
    logic [LO_W-1:0] r;
    r = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = LO_W'(i);
      end
    end
    return r;
  endfunction

  for (genvar i = 0; i < NUM_SLOT; i++) begin : g_rsv
    assign rsv[i] = (i == 0) || (i >= TABLE_DEPTH);
  end

  assign occ_eff = occ_r | rsv;

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    assign grp_full[g] = &occ_eff[g*GRP_W +: GRP_W];
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.set_en) begin
      occ_nxt[cmd.set_idx] = 1'b1;
    end
    if (cmd.clr_en) begin
      occ_nxt[cmd.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      grp_ok_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.load) begin
        grp_ok_r <= ~&grp_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp_r <= first_open(grp_full);
    end
  end

  assign grp_bits   = occ_eff[{grp_r, {LO_W{1'b0}}} +: GRP_W];
  assign free.found = grp_ok_r;
  assign free.slot  = {grp_r, low_free(grp_bits)};
  assign q_occ      = occ_eff[q_idx];

endmodule

[rtl/handle_table_allocator.sv]
// Handle table allocator: create, lookup, get-type and remove on a fixed table.
// Depends on hta_pkg, hta_ram and hta_free_find.
//
// Usage:
//   Drive in_item and raise start; the item transfers at a rising edge where
//   start is high and busy is low. busy is high in the cycle after each
//   transfer, so no new item is taken in that cycle.
//   The result appears on out_item with out_strobe high for exactly one cycle;
//   both are registered from the work state that the transfer enters.
//   The receiver cannot stall; every result is taken in its strobe cycle, and
//   unused fields of a result are zero. The busy cycle is set by the registered
//   read port of the slot RAM and by the lowest-free search, which picks a
//   group of slots in the transfer cycle and the slot within that group in
//   the next cycle, where create also writes the RAM.
//   Slot 0 is never handed out; a full table makes create return 0.
//   Reset (synchronous, active low) clears the occupancy bitmap at once, so
//   the table reads as empty in the first cycle after reset with no clearing
//   pass; the pointer/type RAM itself is not cleared.
module handle_table_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hta_pkg::hta_in_t  in_item,
  output logic              out_strobe,
  output hta_pkg::hta_out_t out_item
);
  import hta_pkg::*;

  hta_state_t          state_r, state_nxt;
  logic                accept, work;
  hta_op_t             op_r;
  logic [HANDLE_W-1:0] h_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [TYPE_W-1:0]   ty_r;
  logic                h_ok;

  logic                out_strobe_r;
  hta_out_t            out_item_r, resp;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [TYPE_W-1:0]   rd_type;
  logic [PTR_W-1:0]    rd_ptr;

  hta_occ_cmd_t        occ_cmd;
  hta_free_t           free;
  logic                q_occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    work      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        busy      = 1'b1;
        work      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_item.opcode;
      h_r   <= in_item.handle_index;
      ptr_r <= PTR_W'(in_item.pointer_value);
      ty_r  <= in_item.entry_type;
    end
  end

  assign h_ok = (h_r != '0) && (32'(h_r) < 32'(TABLE_DEPTH));

  assign ram_raddr = IDX_W'(in_item.handle_index);
  assign ram_we    = work && (op_r == OP_CREATE) && free.found;
  assign ram_waddr = free.slot;
  assign ram_wdata = {ty_r, ptr_r};
  assign {rd_type, rd_ptr} = ram_rdata;

  hta_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    occ_cmd.load    = accept;
    occ_cmd.set_en  = ram_we && (ty_r != TYPE_EMPTY);
    occ_cmd.set_idx = free.slot;
    occ_cmd.clr_en  = work && (op_r == OP_REMOVE) && h_ok;
    occ_cmd.clr_idx = IDX_W'(h_r);
  end

  hta_free_find u_find (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (occ_cmd),
    .q_idx (IDX_W'(h_r)),
    .q_occ (q_occ),
    .free  (free)
  );

  always_comb begin
    resp = '0;
    case (op_r)
      OP_CREATE: begin
        if (free.found) begin
          resp.new_handle = HANDLE_W'(free.slot);
        end
      end
      OP_LOOKUP: begin
        if (h_ok && q_occ) begin
          resp.read_pointer = PTR_FIELD_W'(rd_ptr);
        end
      end
      OP_GETTYPE: begin
        if (h_ok && q_occ) begin
          resp.read_type = rd_type;
        end
      end
      default: resp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_item_r <= resp;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("no result two cycles after transfer");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without a transferred item");

  a_slot_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr != '0))
    else $error("create wrote slot zero");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($countones({out_item.new_handle != '0, out_item.read_pointer != '0,
                                out_item.read_type != '0}) <= 1))
    else $error("more than one result field set");

endmodule
